// ===== sv/touch_button_hold_repeat_assert.svh =====
// Assertion macros for the touch button block
`ifndef TOUCH_BUTTON_HOLD_REPEAT_ASSERT_SVH
`define TOUCH_BUTTON_HOLD_REPEAT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TBHR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch button assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define TBHR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch button assertion failed");

`endif

// ===== sv/tbhr_pkg.sv =====
package tbhr_pkg;

	localparam int unsigned BTN_MARGIN = 8;
	localparam int unsigned BTN_GAP = 8;
	localparam int unsigned BTN_HEIGHT = 50;
	localparam int unsigned BTN_COUNT = 4;
	localparam int unsigned ROW_MIN_WIDTH = BTN_MARGIN * 2 + BTN_GAP * 3;
	localparam int unsigned ROW_MIN_HEIGHT = BTN_MARGIN + BTN_HEIGHT;

	localparam logic [2:0] BTN_NONE = 3'd0;
	localparam logic [2:0] BTN_REPEAT_LO = 3'd3;
	localparam logic [2:0] BTN_REPEAT_HI = 3'd4;

	localparam logic [1:0] CFG_DISP_WIDTH = 2'd0;
	localparam logic [1:0] CFG_DISP_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_REPEAT_START = 2'd2;
	localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd3;

	localparam logic [11:0] RST_DISP_WIDTH = 12'd240;
	localparam logic [11:0] RST_DISP_HEIGHT = 12'd320;
	localparam logic [15:0] RST_REPEAT_START = 16'd400;
	localparam logic [15:0] RST_REPEAT_PERIOD = 16'd150;

	typedef struct packed {
		logic [11:0] disp_width;
		logic [11:0] disp_height;
	} geom_cfg_t;

	typedef struct packed {
		logic [15:0] repeat_start_ms;
		logic [15:0] repeat_period_ms;
	} rep_cfg_t;

	typedef struct packed {
		logic        touch_down;
		logic [11:0] touch_x;
		logic [11:0] touch_y;
		logic        edit_view;
		logic [31:0] now_ms;
	} touch_item_t;

	typedef struct packed {
		logic       command_valid;
		logic [2:0] command_button;
		logic       command_is_press;
		logic       redraw_needed;
		logic [2:0] current_button;
	} result_t;

endpackage

// ===== sv/tbhr_hit.sv =====
module tbhr_hit (
	input  logic                 touch_down,
	input  logic [11:0]          touch_x,
	input  logic [11:0]          touch_y,
	input  tbhr_pkg::geom_cfg_t  geom,
	output logic [2:0]           hit
);

	logic [9:0]  bw;
	logic [10:0] step;
	logic [11:0] row_top;
	logic [12:0] row_end;
	logic        row_ok;
	logic [13:0] left;
	logic [13:0] right;
	logic [13:0] x_ext;

	assign bw = 10'((geom.disp_width - 12'(tbhr_pkg::ROW_MIN_WIDTH)) >> 2);
	assign step = {1'b0, bw} + 11'(tbhr_pkg::BTN_GAP);
	assign row_top = geom.disp_height - 12'(tbhr_pkg::ROW_MIN_HEIGHT);
	assign row_end = {1'b0, row_top} + 13'(tbhr_pkg::BTN_HEIGHT);
	assign x_ext = {2'b00, touch_x};

	assign row_ok = touch_down
		&& (geom.disp_width >= 12'(tbhr_pkg::ROW_MIN_WIDTH))
		&& (geom.disp_height >= 12'(tbhr_pkg::ROW_MIN_HEIGHT))
		&& (touch_y >= row_top) && ({1'b0, touch_y} < row_end);

	// scan from the right so the leftmost match wins
	always_comb begin
		hit = tbhr_pkg::BTN_NONE;
		left = '0;
		right = '0;
		for (int i = tbhr_pkg::BTN_COUNT - 1; i >= 0; i--) begin
			left = 14'(tbhr_pkg::BTN_MARGIN) + 14'(i) * {3'b000, step};
			right = left + {4'b0000, bw};
			if (row_ok && x_ext >= left && x_ext < right) begin
				hit = 3'(i + 1);
			end
		end
	end

endmodule

// ===== sv/tbhr_ctrl.sv =====
module tbhr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  tbhr_pkg::touch_item_t  item,
	input  logic [2:0]             hit,
	input  tbhr_pkg::rep_cfg_t     rep,
	output tbhr_pkg::result_t      res
);

	logic        held_q;
	logic        action_sent_q;
	logic [2:0]  held_button_q;
	logic [31:0] hold_start_q;
	logic [31:0] last_repeat_q;

	logic        held_d;
	logic        action_sent_d;
	logic [2:0]  held_button_d;
	logic [31:0] hold_start_d;
	logic [31:0] last_repeat_d;

	logic [31:0] since_start;
	logic [31:0] since_repeat;
	logic        repeating;
	logic        due;

	assign since_start = item.now_ms - hold_start_q;
	assign since_repeat = item.now_ms - last_repeat_q;
	assign repeating = item.edit_view
		&& (hit == tbhr_pkg::BTN_REPEAT_LO || hit == tbhr_pkg::BTN_REPEAT_HI);
	assign due = (since_start >= {16'd0, rep.repeat_start_ms})
		&& (since_repeat >= {16'd0, rep.repeat_period_ms});

	always_comb begin
		held_d = held_q;
		action_sent_d = action_sent_q;
		held_button_d = held_button_q;
		hold_start_d = hold_start_q;
		last_repeat_d = last_repeat_q;
		res = '0;
		if (hit != tbhr_pkg::BTN_NONE) begin
			if (!held_q) begin
				held_d = 1'b1;
				held_button_d = hit;
				action_sent_d = repeating;
				hold_start_d = item.now_ms;
				last_repeat_d = item.now_ms;
				res.redraw_needed = 1'b1;
				if (repeating) begin
					res.command_valid = 1'b1;
					res.command_is_press = 1'b1;
					res.command_button = hit;
				end
			end else if (held_button_q == hit && repeating && due) begin
				last_repeat_d = item.now_ms;
				action_sent_d = 1'b1;
				res.command_valid = 1'b1;
				res.command_is_press = 1'b1;
				res.command_button = hit;
			end
		end else if (held_q) begin
			held_d = 1'b0;
			action_sent_d = 1'b0;
			held_button_d = tbhr_pkg::BTN_NONE;
			res.redraw_needed = 1'b1;
			if (held_button_q != tbhr_pkg::BTN_NONE && !action_sent_q) begin
				res.command_valid = 1'b1;
				res.command_button = held_button_q;
			end
		end
		res.current_button = held_button_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			action_sent_q <= 1'b0;
			held_button_q <= tbhr_pkg::BTN_NONE;
			hold_start_q <= '0;
			last_repeat_q <= '0;
		end else if (step_en) begin
			held_q <= held_d;
			action_sent_q <= action_sent_d;
			held_button_q <= held_button_d;
			hold_start_q <= hold_start_d;
			last_repeat_q <= last_repeat_d;
		end
	end

endmodule

// ===== sv/touch_button_hold_repeat.sv =====
// Channel   Dir  Width  Contents
// s_*       in   64     touch sample
// m_*       out  16     button result
// cfg_*     in   2+16   register write (width, height, repeat start, repeat period)
//
// One sample per cycle while the result register is not stalled.
// Input register, then hit test and hold/repeat update, then result register.
// Reset clears the hold state and loads 240, 320, 400 and 150 into the registers.
// A stalled result holds in the result register; the input register keeps
// taking samples while the result register can drain.
module touch_button_hold_repeat (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] touch_down, [12:1] touch_x, [24:13] touch_y, [25] edit_view, [57:26] now_ms
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] command_valid, [3:1] command_button, [4] command_is_press,
	// [5] redraw_needed, [8:6] current_button
	output logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	tbhr_pkg::geom_cfg_t   geom_q;
	tbhr_pkg::rep_cfg_t    rep_q;
	tbhr_pkg::touch_item_t item_in;
	tbhr_pkg::touch_item_t item_s1;
	logic                  valid_s1;
	tbhr_pkg::result_t     res_comb;
	tbhr_pkg::result_t     res_s2;
	logic                  valid_s2;
	logic                  s_xfer;
	logic                  adv;
	logic [2:0]            hit;

	assign item_in.touch_down = s_tdata[0];
	assign item_in.touch_x = s_tdata[12:1];
	assign item_in.touch_y = s_tdata[24:13];
	assign item_in.edit_view = s_tdata[25];
	assign item_in.now_ms = s_tdata[57:26];

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.disp_width <= tbhr_pkg::RST_DISP_WIDTH;
			geom_q.disp_height <= tbhr_pkg::RST_DISP_HEIGHT;
			rep_q.repeat_start_ms <= tbhr_pkg::RST_REPEAT_START;
			rep_q.repeat_period_ms <= tbhr_pkg::RST_REPEAT_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				tbhr_pkg::CFG_DISP_WIDTH: geom_q.disp_width <= cfg_wdata[11:0];
				tbhr_pkg::CFG_DISP_HEIGHT: geom_q.disp_height <= cfg_wdata[11:0];
				tbhr_pkg::CFG_REPEAT_START: rep_q.repeat_start_ms <= cfg_wdata;
				tbhr_pkg::CFG_REPEAT_PERIOD: rep_q.repeat_period_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1 <= item_in;
		end
	end

	tbhr_hit u_hit (
		.touch_down (item_s1.touch_down),
		.touch_x    (item_s1.touch_x),
		.touch_y    (item_s1.touch_y),
		.geom       (geom_q),
		.hit        (hit)
	);

	tbhr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.hit     (hit),
		.rep     (rep_q),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {7'd0, res_s2.current_button, res_s2.redraw_needed,
		res_s2.command_is_press, res_s2.command_button, res_s2.command_valid};

endmodule

// ===== sv/tbhr_checker.sv =====
`include "touch_button_hold_repeat_assert.svh"

module tbhr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled result
	`TBHR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// no command means no button and no press mark
	`TBHR_ASSERT_NOW(a_idle_clean, m_tvalid && !m_tdata[0], m_tdata[3:1] == 3'd0 && !m_tdata[4])

	// a command names a real button
	`TBHR_ASSERT_NOW(a_cmd_button, m_tvalid && m_tdata[0], m_tdata[3:1] != 3'd0 && m_tdata[3:1] <= 3'd4)

	// a release drops the held button and redraws
	`TBHR_ASSERT_NOW(a_release, m_tvalid && m_tdata[0] && !m_tdata[4], m_tdata[8:6] == 3'd0 && m_tdata[5])

endmodule

bind touch_button_hold_repeat tbhr_checker u_tbhr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
